// File: sv/jdrr_pkg.sv
// shared types, constants and codes for the round-robin job dispatcher
package jdrr_pkg;

   localparam int FUNC_W    = 3;
   localparam int TAG_W     = 16;
   localparam int SIDX_W    = 4;
   localparam int STAT_W    = 2;
   localparam int ACT_W     = 5;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;

   localparam int SLOTS_DEFAULT       = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SUBMIT   = 3'd0,
      FUNC_COMPLETE = 3'd1,
      FUNC_TICK     = 3'd2,
      FUNC_JOIN     = 3'd3,
      FUNC_RESTART  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      K_SUBMIT,
      K_COMPLETE,
      K_TICK,
      K_JOIN,
      K_RESTART,
      K_NOP
   } cmd_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_CLOSED    = 2'd2,
      STAT_IDLE_SLOT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_FIND
   } back_state_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [TAG_W-1:0]  tag;
      logic              slot_ok;
      logic [SIDX_W-1:0] slot_index;
   } cmd_type;

   // packed so that dispatched lands in bit 0
   typedef struct packed {
      logic              drained;
      status_type        status;
      logic [TAG_W-1:0]  dispatch_job;
      logic [SIDX_W-1:0] dispatch_slot;
      logic              dispatched;
   } rsp_type;

endpackage

// File: sv/jdrr_front.sv
// front end: takes requests, classifies them and queues them for the back end
module jdrr_front #(
   parameter int SLOTS = jdrr_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [jdrr_pkg::REQ_W-1:0] req_tdata,
   output logic                    cmd_valid,
   input  logic                    cmd_pop,
   output jdrr_pkg::cmd_type       cmd
);
   import jdrr_pkg::*;

   logic [FUNC_W-1:0] func;
   cmd_type           dec;
   cmd_type           q_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign func = req_tdata[FUNC_W-1:0];

   always_comb begin
      dec.tag        = req_tdata[FUNC_W +: TAG_W];
      dec.slot_index = req_tdata[FUNC_W+TAG_W +: SIDX_W];
      dec.slot_ok    = (32'(dec.slot_index) < SLOTS);
      unique case (func)
         FUNC_SUBMIT:   dec.kind = K_SUBMIT;
         FUNC_COMPLETE: dec.kind = K_COMPLETE;
         FUNC_TICK:     dec.kind = K_TICK;
         FUNC_JOIN:     dec.kind = K_JOIN;
         FUNC_RESTART:  dec.kind = K_RESTART;
         default:       dec.kind = K_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule

// File: sv/jdrr_pick.sv
// round-robin search for the first idle slot at or after the start, wrapping
module jdrr_pick #(
   parameter int SLOTS  = jdrr_pkg::SLOTS_DEFAULT,
   parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CNT_W  = $clog2(SLOTS + 1)
) (
   input  logic [SLOTS-1:0]  busy,
   input  logic [SLOT_W-1:0] start,
   input  logic [CNT_W-1:0]  n,
   output logic              found,
   output logic [SLOT_W-1:0] idx,
   output logic [SLOT_W-1:0] next_start
);

   logic              found_hi, found_any;
   logic [SLOT_W-1:0] idx_hi, idx_any;
   logic [CNT_W-1:0]  idx_inc;

   always_comb begin
      found_hi  = 1'b0;
      found_any = 1'b0;
      idx_hi    = '0;
      idx_any   = '0;
      // scan downwards so the lowest qualifying slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy[i] && (i < int'(n))) begin
            found_any = 1'b1;
            idx_any   = SLOT_W'(i);
            if (i >= int'(start)) begin
               found_hi = 1'b1;
               idx_hi   = SLOT_W'(i);
            end
         end
      end
   end

   assign found      = found_any;
   assign idx        = found_hi ? idx_hi : idx_any;
   assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
   assign next_start = (idx_inc == n) ? '0 : SLOT_W'(idx_inc);

endmodule

// File: sv/jdrr_back.sv
// back end: job tag queue, slot busy map, search sequencer and result register
module jdrr_back #(
   parameter int SLOTS       = jdrr_pkg::SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = jdrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [jdrr_pkg::ACT_W-1:0] csr_data,
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   input  jdrr_pkg::cmd_type         cmd,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [jdrr_pkg::RSP_W-1:0] rsp_tdata
);
   import jdrr_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   back_state_type    state_ff, state_in;
   logic [ACT_W-1:0]  act_ff;
   logic [SLOTS-1:0]  busy_ff, busy_in;
   logic [SLOT_W-1:0] start_ff, start_in;
   logic [SLOT_W-1:0] srch_ff, srch_in;
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              join_ff, join_in;
   logic              accept_ff, accept_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [TAG_W-1:0]  mem [QUEUE_DEPTH];

   logic [CNT_W-1:0]  n;
   logic [QPTR_W:0]   tail_sum;
   logic [QPTR_W-1:0] tail;
   logic [SLOT_W-1:0] bidx;
   logic              out_free, load, mem_we;
   logic              pick_found;
   logic [SLOT_W-1:0] pick_idx, pick_next;

   // active count clamped to 1..SLOTS
   always_comb begin
      if (act_ff == '0) begin
         n = CNT_W'(1);
      end else if (32'(act_ff) > SLOTS) begin
         n = CNT_W'(SLOTS);
      end else begin
         n = CNT_W'(act_ff);
      end
   end

   assign tail_sum = (QPTR_W+1)'(head_ff) + (QPTR_W+1)'(count_ff);
   assign tail     = (tail_sum >= (QPTR_W+1)'(QUEUE_DEPTH)) ?
                     QPTR_W'(tail_sum - (QPTR_W+1)'(QUEUE_DEPTH)) : QPTR_W'(tail_sum);
   assign bidx     = SLOT_W'(cmd.slot_index);
   assign out_free = !rsp_valid_ff || rsp_tready;

   jdrr_pick #(
      .SLOTS (SLOTS),
      .SLOT_W(SLOT_W),
      .CNT_W (CNT_W)
   ) u_pick (
      .busy      (busy_ff),
      .start     (srch_ff),
      .n         (n),
      .found     (pick_found),
      .idx       (pick_idx),
      .next_start(pick_next)
   );

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      start_in     = start_ff;
      srch_in      = srch_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      join_in      = join_ff;
      accept_in    = accept_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      load         = 1'b0;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      rsp_in.dispatched    = rsp_ff.dispatched;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == K_TICK && count_ff != '0) begin
                  cmd_pop  = 1'b1;
                  srch_in  = start_ff;
                  state_in = ST_ALIGN;
               end else if (out_free) begin
                  cmd_pop              = 1'b1;
                  load                 = 1'b1;
                  rsp_in.dispatched    = 1'b0;
                  rsp_in.dispatch_slot = '0;
                  rsp_in.dispatch_job  = '0;
                  rsp_in.status        = STAT_OK;
                  unique case (cmd.kind)
                     K_SUBMIT: begin
                        if (!accept_ff) begin
                           rsp_in.status = STAT_CLOSED;
                        end else if (count_ff == QCNT_W'(QUEUE_DEPTH)) begin
                           rsp_in.status = STAT_FULL;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     K_COMPLETE: begin
                        if (cmd.slot_ok && busy_ff[bidx]) begin
                           busy_in[bidx] = 1'b0;
                        end else begin
                           rsp_in.status = STAT_IDLE_SLOT;
                        end
                     end
                     K_JOIN: begin
                        join_in   = 1'b1;
                        accept_in = 1'b0;
                     end
                     K_RESTART: begin
                        join_in   = 1'b0;
                        accept_in = 1'b1;
                        head_in   = '0;
                        count_in  = '0;
                        busy_in   = '0;
                        start_in  = '0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_ALIGN: begin
            // bring a working copy of the search start below the active count,
            // one subtract a cycle; the stored start only moves on a dispatch or a restart
            if (CNT_W'(srch_ff) >= n) begin
               srch_in = SLOT_W'(CNT_W'(srch_ff) - n);
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (out_free) begin
               load                 = 1'b1;
               state_in             = ST_IDLE;
               rsp_in.dispatched    = 1'b0;
               rsp_in.dispatch_slot = '0;
               rsp_in.dispatch_job  = '0;
               rsp_in.status        = STAT_OK;
               if (pick_found) begin
                  busy_in[pick_idx]    = 1'b1;
                  head_in              = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_ff + 1'b1;
                  count_in             = count_ff - 1'b1;
                  start_in             = pick_next;
                  rsp_in.dispatched    = 1'b1;
                  rsp_in.dispatch_slot = SIDX_W'(pick_idx);
                  rsp_in.dispatch_job  = rd_tag_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_in.drained = join_in && (count_in == '0) && (busy_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= ACT_RESET;
         busy_ff      <= '0;
         start_ff     <= '0;
         srch_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         join_ff      <= 1'b0;
         accept_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) begin
            act_ff <= csr_data;
         end
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         srch_ff      <= srch_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         join_ff      <= join_in;
         accept_ff    <= accept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // tag store: head entry read every cycle, settles before a search reaches it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail] <= cmd.tag;
      end
      rd_tag_ff <= mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue count beyond depth");

   a_start_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND |-> CNT_W'(srch_ff) < n)
      else $error("slot search started outside active range");

   a_join_closed: assert property (@(posedge clock) disable iff (reset)
      join_ff |-> !accept_ff)
      else $error("submissions open after join");

   a_pop_on_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND && out_free && pick_found) |=>
      (count_ff == $past(count_ff) - 1'b1))
      else $error("dispatch did not pop the queue");

endmodule

// File: sv/job_dispatcher_round_robin_slots_unit.sv
// Round-robin job dispatcher: FIFO of job tags handed to idle worker slots.
// Flow: a request passes through the front queue before the back end takes it up, and its
//   result is registered; a dispatch tick on a non-empty queue steps through pop, align
//   and search, with one more align step per subtract when the search start lies at
//   or beyond a lowered active count.
// Throughput: one non-tick request per cycle unless the output stalls or a tick is busy.
// Reset (synchronous): queue, slot map, search start and join cleared, 16 active slots;
//   the tag store is not cleared.
module job_dispatcher_round_robin_slots_unit #(
   parameter int SLOTS       = jdrr_pkg::SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = jdrr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // func[2:0], job_tag[18:3], slot_index[22:19], zero pad [23]
   input  logic [jdrr_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // dispatched[0], dispatch_slot[4:1], dispatch_job[20:5], status[22:21], drained[23]
   output logic [jdrr_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [jdrr_pkg::ACT_W-1:0] csr_data
);
   import jdrr_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   assign csr_ready = 1'b1;

   jdrr_front #(
      .SLOTS(SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   jdrr_back #(
      .SLOTS      (SLOTS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule
